// File: hdl/ads_pkg.sv
// Shared types, constants and microcode for the attack-decay-sustain envelope block.
// Holds the stage and voice entry types, the sustain level table and the control program.
// Depends on nothing; every other file of the block imports it.
package ads_pkg;

  localparam int VOICES_DEFAULT = 9;

  localparam int LEVEL_W = 17;
  localparam int TIME_W  = 32;
  localparam int DEN_W   = 16;
  localparam int Q_BITS  = 17;
  localparam int CNT_W   = 5;
  localparam int REM_W   = 52;
  localparam int SusDiv  = 127;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 17'h10000;

  localparam logic [1:0] MODE_TRIGGER = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_TICK    = 2'd2;

  typedef enum logic [1:0] {
    STG_OFF     = 2'd0,
    STG_ATTACK  = 2'd1,
    STG_DECAY   = 2'd2,
    STG_SUSTAIN = 2'd3
  } stage_t;

  typedef struct packed {
    stage_t               stage;
    logic [LEVEL_W-1:0]   level;
    logic [TIME_W-1:0]    last;
  } voice_entry_t;

  typedef logic [LEVEL_W-1:0] sus_table_t [128];

  function automatic sus_table_t build_sus_table();
    sus_table_t t;
    for (int i = 0; i < 128; i++) begin
      t[i] = LEVEL_W'((i * 65536 + 63) / SusDiv);
    end
    return t;
  endfunction

  localparam sus_table_t SUS_TABLE = build_sus_table();

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_FETCH,
    OP_DINIT,
    OP_DSTEP,
    OP_APPLY,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_IN,
    C_NO_DIV,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_t;

  localparam int UC_AW    = 3;
  localparam int UC_DEPTH = 8;

  typedef logic [UC_AW-1:0] step_t;

  localparam step_t S_IDLE  = 3'd0;
  localparam step_t S_FETCH = 3'd1;
  localparam step_t S_DINIT = 3'd2;
  localparam step_t S_DSTEP = 3'd3;
  localparam step_t S_APPLY = 3'd4;
  localparam step_t S_WAIT  = 3'd5;
  localparam step_t S_EMIT  = 3'd6;
  localparam step_t S_SPARE = 3'd7;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic no_div;
    logic div_more;
    logic out_busy;
  } status_t;

  localparam ucode_t UCODE [UC_DEPTH] = '{
    '{OP_LOAD,  C_NO_IN,    S_IDLE},
    '{OP_FETCH, C_NONE,     S_IDLE},
    '{OP_DINIT, C_NO_DIV,   S_APPLY},
    '{OP_DSTEP, C_DIV_MORE, S_DSTEP},
    '{OP_APPLY, C_NONE,     S_IDLE},
    '{OP_NONE,  C_OUT_BUSY, S_WAIT},
    '{OP_EMIT,  C_ALWAYS,   S_IDLE},
    '{OP_NONE,  C_ALWAYS,   S_IDLE}
  };

endpackage

// File: hdl/ads_envelope_generator_core.sv
// Top level of the per-voice attack-decay-sustain envelope generator.
// Depends on ads_pkg and instantiates ads_sequencer and ads_datapath.
//
// Usage: the input channel carries one item per trigger, release or tick, with the
// voice index, the current millisecond time and that voice's settings. The block
// answers every item with exactly one result: voice, stage and level after the step.
// Both channels use valid and stall; an item moves when valid is high and stall low.
// A tick on an active, in-range voice that is attacking or decaying runs the 17 steps of
// the restoring divider before its result shows; every other item skips the divider.
// A new item can be taken in the cycle the result appears, and none is taken while an
// item is in progress. The output register holds a result while the receiver stalls; the
// sequencer then waits before its final step and a further item is held off until
// that result is taken. Synchronous reset puts every voice off at full level with
// time zero and leaves the output channel empty; items are taken right after reset.
module ads_envelope_generator_core #(
  parameter int VOICES = ads_pkg::VOICES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_voice,
  input  logic [31:0] in_now_ms,
  input  logic        in_voice_active,
  input  logic [7:0]  in_attack_setting,
  input  logic [7:0]  in_decay_setting,
  input  logic [6:0]  in_sustain_setting,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_voice_out,
  output logic [1:0]  out_stage_out,
  output logic [16:0] out_level_out
);
  import ads_pkg::*;

  op_t     op;
  status_t status;

  ads_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .op       (op),
    .in_stall (in_stall)
  );

  ads_datapath #(.VOICES(VOICES)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .op                 (op),
    .status             (status),
    .in_mode            (in_mode),
    .in_voice           (in_voice),
    .in_now_ms          (in_now_ms),
    .in_voice_active    (in_voice_active),
    .in_attack_setting  (in_attack_setting),
    .in_decay_setting   (in_decay_setting),
    .in_sustain_setting (in_sustain_setting),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_voice_out      (out_voice_out),
    .out_stage_out      (out_stage_out),
    .out_level_out      (out_level_out)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block took a second item right after accepting one");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level_out <= FULL_LEVEL)
    else $error("level above full scale");

  a_off_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stage_out == STG_OFF |-> out_level_out == FULL_LEVEL)
    else $error("off voice reported below full level");

  a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && 32'(out_voice_out) >= 32'(VOICES) |->
      out_stage_out == STG_OFF && out_level_out == FULL_LEVEL)
    else $error("unknown voice reported a live envelope");

endmodule

// File: hdl/ads_voice_store.sv
// Per-voice envelope state: stage, level and time of the last update.
// One write port and one read port; reset loads the off state at full level.
// Depends on ads_pkg for the entry type and reset values.
module ads_voice_store #(
  parameter int VOICES = ads_pkg::VOICES_DEFAULT,
  localparam int IdxW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 we,
  input  logic [IdxW-1:0]      widx,
  input  ads_pkg::voice_entry_t wdata,
  input  logic [IdxW-1:0]      ridx,
  output ads_pkg::voice_entry_t rdata
);
  import ads_pkg::*;

  voice_entry_t entry_r [VOICES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        entry_r[i] <= '{stage: STG_OFF, level: FULL_LEVEL, last: '0};
      end
    end else if (we) begin
      entry_r[widx] <= wdata;
    end
  end

  assign rdata = entry_r[ridx];

endmodule

// File: hdl/ads_sequencer.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Drives the datapath operation and the input stall from the current step.
// Depends on ads_pkg for the program and the control and status types.
module ads_sequencer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  ads_pkg::status_t status,
  output ads_pkg::op_t     op,
  output logic             in_stall
);
  import ads_pkg::*;

  step_t  pc_r;
  step_t  pc_nxt;
  ucode_t cw;
  logic   take;

  assign cw = UCODE[pc_r];

  always_comb begin
    unique case (cw.cond)
      C_NONE:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_IN:    take = !in_valid;
      C_NO_DIV:   take = status.no_div;
      C_DIV_MORE: take = status.div_more;
      C_OUT_BUSY: take = status.out_busy;
      default:    take = 1'b1;
    endcase
  end

  always_comb begin
    pc_nxt = take ? cw.target : step_t'(pc_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign op       = cw.op;
  assign in_stall = (pc_r != S_IDLE);

endmodule

// File: hdl/ads_datapath.sv
// Envelope datapath: input latch, voice state access, restoring divider and update logic.
// Holds the output register; each operation is selected by the sequencer.
// Depends on ads_pkg and instantiates ads_voice_store.
module ads_datapath #(
  parameter int VOICES = ads_pkg::VOICES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ads_pkg::op_t       op,
  output ads_pkg::status_t   status,
  input  logic [1:0]         in_mode,
  input  logic [3:0]         in_voice,
  input  logic [31:0]        in_now_ms,
  input  logic               in_voice_active,
  input  logic [7:0]         in_attack_setting,
  input  logic [7:0]         in_decay_setting,
  input  logic [6:0]         in_sustain_setting,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_voice_out,
  output logic [1:0]         out_stage_out,
  output logic [16:0]        out_level_out
);
  import ads_pkg::*;

  localparam int IdxW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int VExtW = ((IdxW > 4) ? IdxW : 4) + 1;

  logic [1:0]         mode_r;
  logic [3:0]         voice_r;
  logic [TIME_W-1:0]  now_r;
  logic               active_r;
  logic [7:0]         att_r;
  logic [7:0]         dec_r;
  logic [6:0]         sus_r;
  stage_t             stg_r;
  logic [LEVEL_W-1:0] lvl_r;
  logic [TIME_W-1:0]  elapsed_r;
  logic [DEN_W-1:0]   den_r;
  logic [REM_W-1:0]   rem_r;
  logic [31:0]        dsh_r;
  logic [Q_BITS-1:0]  q_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               sat_r;
  stage_t             res_stg_r;
  logic [LEVEL_W-1:0] res_lvl_r;
  logic               out_valid_r;
  logic [3:0]         out_voice_r;
  logic [1:0]         out_stage_r;
  logic [LEVEL_W-1:0] out_level_r;

  logic [VExtW-1:0]   voice_ext;
  logic               in_range;
  logic [IdxW-1:0]    vidx;
  voice_entry_t       rd;
  voice_entry_t       wr;
  logic               we;
  logic [7:0]         sel_setting;
  logic [35:0]        e10;
  logic [34:0]        e5;
  logic               ge;
  logic [LEVEL_W-1:0] inc;
  logic [LEVEL_W-1:0] sus_lvl;
  logic [LEVEL_W:0]   sum;
  logic [LEVEL_W:0]   diff;
  stage_t             new_stg;
  logic [LEVEL_W-1:0] new_lvl;
  logic [TIME_W-1:0]  new_last;

  assign voice_ext = VExtW'(voice_r);
  assign in_range  = voice_ext < VExtW'(VOICES);
  assign vidx      = in_range ? voice_ext[IdxW-1:0] : '0;

  ads_voice_store #(.VOICES(VOICES)) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (we),
    .widx  (vidx),
    .wdata (wr),
    .ridx  (vidx),
    .rdata (rd)
  );

  assign sel_setting = (rd.stage == STG_ATTACK) ? att_r : dec_r;
  assign e10 = ({4'b0, elapsed_r} << 3) + ({4'b0, elapsed_r} << 1);
  assign e5  = ({3'b0, elapsed_r} << 2) + {3'b0, elapsed_r};
  assign ge  = rem_r >= REM_W'(dsh_r);
  assign sus_lvl = SUS_TABLE[sus_r];

  always_comb begin
    if (sat_r || q_r > FULL_LEVEL) begin
      inc = FULL_LEVEL;
    end else begin
      inc = q_r;
    end
  end

  assign sum  = {1'b0, lvl_r} + {1'b0, inc};
  assign diff = {1'b0, lvl_r} - {1'b0, inc};

  always_comb begin
    new_stg  = stg_r;
    new_lvl  = lvl_r;
    new_last = elapsed_r;
    new_last = rd.last;
    if (mode_r == MODE_TRIGGER) begin
      if (att_r != '0 || dec_r != '0) begin
        new_stg  = STG_ATTACK;
        new_lvl  = '0;
        new_last = now_r;
      end else begin
        new_stg = STG_SUSTAIN;
        new_lvl = sus_lvl;
      end
    end else if (mode_r == MODE_RELEASE) begin
      new_stg = STG_OFF;
      new_lvl = FULL_LEVEL;
    end else if (mode_r == MODE_TICK && active_r && stg_r != STG_OFF) begin
      new_last = now_r;
      if (stg_r == STG_ATTACK) begin
        if (sum >= {1'b0, FULL_LEVEL}) begin
          new_lvl = FULL_LEVEL;
          new_stg = (dec_r != '0) ? STG_DECAY : STG_SUSTAIN;
        end else begin
          new_lvl = sum[LEVEL_W-1:0];
        end
      end else if (stg_r == STG_DECAY) begin
        if (diff[LEVEL_W] || diff[LEVEL_W-1:0] <= sus_lvl) begin
          new_lvl = sus_lvl;
          new_stg = STG_SUSTAIN;
        end else begin
          new_lvl = diff[LEVEL_W-1:0];
        end
      end
    end
  end

  always_comb begin
    wr = '{stage: new_stg, level: new_lvl, last: new_last};
    we = (op == OP_APPLY) && in_range;
  end

  always_comb begin
    status.no_div   = !(in_range && mode_r == MODE_TICK && active_r &&
                        (stg_r == STG_ATTACK || stg_r == STG_DECAY));
    status.div_more = (cnt_r != '0);
    status.out_busy = out_valid_r && out_stall;
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        mode_r   <= in_mode;
        voice_r  <= in_voice;
        now_r    <= in_now_ms;
        active_r <= in_voice_active;
        att_r    <= in_attack_setting;
        dec_r    <= in_decay_setting;
        sus_r    <= in_sustain_setting;
      end
      OP_FETCH: begin
        stg_r     <= rd.stage;
        lvl_r     <= rd.level;
        elapsed_r <= now_r - rd.last;
        den_r     <= DEN_W'(16'd10 + (16'(sel_setting) * 16'd156));
      end
      OP_DINIT: begin
        rem_r <= {e10, 16'b0};
        dsh_r <= {den_r, 16'b0};
        sat_r <= e5 >= 35'(den_r);
        q_r   <= '0;
        cnt_r <= CNT_W'(Q_BITS - 1);
      end
      OP_DSTEP: begin
        if (ge) begin
          rem_r <= rem_r - REM_W'(dsh_r);
        end
        q_r   <= {q_r[Q_BITS-2:0], ge};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 1'b1;
      end
      OP_APPLY: begin
        res_stg_r <= in_range ? new_stg : STG_OFF;
        res_lvl_r <= in_range ? new_lvl : FULL_LEVEL;
      end
      OP_EMIT: begin
        out_voice_r <= voice_r;
        out_stage_r <= res_stg_r;
        out_level_r <= res_lvl_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_voice_out = out_voice_r;
  assign out_stage_out = out_stage_r;
  assign out_level_out = out_level_r;

endmodule

// File: verif/ads_envelope_generator_core_tb.sv
// Self-checking testbench for ads_envelope_generator_core: directed and random envelope items.
// Predicts stage and level per voice at the moment each item is taken and checks every result.
// Depends on ads_pkg and the RTL of the envelope generator core.
module ads_envelope_generator_core_tb;
  import ads_pkg::*;

  localparam int NV = VOICES_DEFAULT;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [1:0]  mode;
    logic [3:0]  voice;
    logic [31:0] now;
    logic        active;
    logic [7:0]  att;
    logic [7:0]  dec;
    logic [6:0]  sus;
    bit          hold;
  } env_item_t;

  typedef struct {
    logic [3:0]  voice;
    stage_t      stage;
    logic [16:0] level;
  } env_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = '0;
  logic [3:0]  in_voice = '0;
  logic [31:0] in_now_ms = '0;
  logic        in_voice_active = 1'b0;
  logic [7:0]  in_attack_setting = '0;
  logic [7:0]  in_decay_setting = '0;
  logic [6:0]  in_sustain_setting = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_voice_out;
  logic [1:0]  out_stage_out;
  logic [16:0] out_level_out;

  env_item_t   pending_items[$];
  env_result_t expected_results[$];
  env_item_t   cur_item;
  stage_t      model_stage [NV];
  logic [16:0] model_level [NV];
  logic [31:0] model_last [NV];
  int          sent_cnt = 0;
  int          got_cnt = 0;
  int          total_items = 0;
  int          errors = 0;
  int          cycle_cnt = 0;
  int          idle_cycles = 0;
  logic        steady;

  assign steady = (cycle_cnt >= 6000) && (cycle_cnt < 10000);

  ads_envelope_generator_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_voice           (in_voice),
    .in_now_ms          (in_now_ms),
    .in_voice_active    (in_voice_active),
    .in_attack_setting  (in_attack_setting),
    .in_decay_setting   (in_decay_setting),
    .in_sustain_setting (in_sustain_setting),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_voice_out      (out_voice_out),
    .out_stage_out      (out_stage_out),
    .out_level_out      (out_level_out)
  );

  always #5 clk = ~clk;

  function automatic logic [16:0] sustain_q16(input logic [6:0] s);
    return 17'((int'(s) * 65536 + 63) / 127);
  endfunction

  function automatic logic [16:0] ms_increment(input logic [31:0] elapsed,
                                               input logic [7:0] setting);
    longint unsigned den;
    longint unsigned q;
    den = 64'd10 + 64'd156 * 64'(setting);
    q = (64'(elapsed) * 64'd655360) / den;
    if (q > 64'd65536) q = 64'd65536;
    return 17'(q);
  endfunction

  // Applies one item to the predicted voice state and returns the result it causes.
  function automatic env_result_t step_voice(input env_item_t it);
    env_result_t r;
    logic [31:0] elapsed;
    int          lvl;
    int          floor_lvl;
    int          v;
    r.voice = it.voice;
    if (it.voice >= NV) begin
      r.stage = STG_OFF;
      r.level = FULL_LEVEL;
      return r;
    end
    v = it.voice;
    case (it.mode)
      MODE_TRIGGER: begin
        if (it.att != 0 || it.dec != 0) begin
          model_stage[v] = STG_ATTACK;
          model_level[v] = '0;
          model_last[v] = it.now;
        end else begin
          model_stage[v] = STG_SUSTAIN;
          model_level[v] = sustain_q16(it.sus);
        end
      end
      MODE_RELEASE: begin
        model_stage[v] = STG_OFF;
        model_level[v] = FULL_LEVEL;
      end
      MODE_TICK: begin
        if (it.active && model_stage[v] != STG_OFF) begin
          elapsed = it.now - model_last[v];
          model_last[v] = it.now;
          if (model_stage[v] == STG_ATTACK) begin
            lvl = int'(model_level[v]) + int'(ms_increment(elapsed, it.att));
            if (lvl >= int'(FULL_LEVEL)) begin
              lvl = int'(FULL_LEVEL);
              model_stage[v] = (it.dec != 0) ? STG_DECAY : STG_SUSTAIN;
            end
            model_level[v] = 17'(lvl);
          end else if (model_stage[v] == STG_DECAY) begin
            lvl = int'(model_level[v]) - int'(ms_increment(elapsed, it.dec));
            floor_lvl = int'(sustain_q16(it.sus));
            if (lvl <= floor_lvl) begin
              lvl = floor_lvl;
              model_stage[v] = STG_SUSTAIN;
            end
            model_level[v] = 17'(lvl);
          end
        end
      end
      default: ;
    endcase
    r.stage = model_stage[v];
    r.level = model_level[v];
    return r;
  endfunction

  function automatic env_item_t mk(input logic [1:0] mode, input logic [3:0] voice,
                                   input logic [31:0] now, input logic active,
                                   input logic [7:0] att, input logic [7:0] dec,
                                   input logic [6:0] sus);
    env_item_t it;
    it.mode = mode;
    it.voice = voice;
    it.now = now;
    it.active = active;
    it.att = att;
    it.dec = dec;
    it.sus = sus;
    it.hold = 1'b0;
    return it;
  endfunction

  always @(posedge clk) begin : drive_items
    logic take;
    take = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
      for (int i = 0; i < NV; i++) begin
        model_stage[i] = STG_OFF;
        model_level[i] = FULL_LEVEL;
        model_last[i] = '0;
      end
    end else begin
      if (take) begin
        expected_results.push_back(step_voice(cur_item));
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && (steady || $urandom_range(0, 99) >= 20) &&
            (!pending_items[0].hold || sent_cnt + int'(take) == got_cnt)) begin
          cur_item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_mode <= cur_item.mode;
          in_voice <= cur_item.voice;
          in_now_ms <= cur_item.now;
          in_voice_active <= cur_item.active;
          in_attack_setting <= cur_item.att;
          in_decay_setting <= cur_item.dec;
          in_sustain_setting <= cur_item.sus;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    env_result_t want;
    out_stall <= !steady && ($urandom_range(0, 99) < 20);
    if (rst_n && out_valid && !out_stall) begin
      got_cnt <= got_cnt + 1;
      if (expected_results.size() == 0) begin
        $error("unexpected result for voice %0d", out_voice_out);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_voice_out !== want.voice) begin
          $error("voice_out: expected %0d, got %0d", want.voice, out_voice_out);
          errors++;
        end
        if (out_stage_out !== want.stage) begin
          $error("stage_out: expected %0d, got %0d", want.stage, out_stage_out);
          errors++;
        end
        if (out_level_out !== want.level) begin
          $error("level_out: expected %0d, got %0d", want.level, out_level_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    env_item_t   it;
    int          seq_items;
    int          directed_cnt;
    int          v;
    int          n;
    logic [31:0] t;
    logic [7:0]  a;
    logic [7:0]  d;
    logic [6:0]  s;

    pending_items.push_back(mk(MODE_TICK, 4'd0, 32'd0, 1'b1, 8'd10, 8'd10, 7'd10));
    pending_items.push_back(mk(MODE_TRIGGER, 4'd0, 32'd0, 1'b1, 8'd0, 8'd0, 7'd127));
    pending_items.push_back(mk(MODE_TRIGGER, 4'd1, 32'd0, 1'b1, 8'd0, 8'd0, 7'd0));
    pending_items.push_back(mk(MODE_TICK, 4'd1, 32'hFFFF_FFFF, 1'b1, 8'd0, 8'd0, 7'd0));
    pending_items.push_back(mk(MODE_TRIGGER, 4'd2, 32'd0, 1'b1, 8'd255, 8'd255, 7'd64));
    pending_items.push_back(mk(MODE_TICK, 4'd2, 32'd100, 1'b0, 8'd255, 8'd255, 7'd64));
    pending_items.push_back(mk(MODE_TICK, 4'd2, 32'd1000, 1'b1, 8'd255, 8'd255, 7'd64));
    pending_items.push_back(mk(MODE_TICK, 4'd2, 32'hFFFF_FFFF, 1'b1, 8'd255, 8'd255, 7'd64));
    pending_items.push_back(mk(MODE_TICK, 4'd2, 32'h0000_0010, 1'b1, 8'd255, 8'd255, 7'd64));
    pending_items.push_back(mk(MODE_TICK, 4'd2, 32'h0010_0000, 1'b1, 8'd255, 8'd0, 7'd64));
    pending_items.push_back(mk(MODE_RELEASE, 4'd2, 32'h0010_0001, 1'b1, 8'd255, 8'd0, 7'd64));
    pending_items.push_back(mk(MODE_TRIGGER, 4'd3, 32'd5000, 1'b1, 8'd1, 8'd0, 7'd100));
    pending_items.push_back(mk(MODE_TICK, 4'd3, 32'd6000, 1'b1, 8'd1, 8'd0, 7'd100));
    pending_items.push_back(mk(MODE_TRIGGER, 4'd4, 32'd7, 1'b1, 8'd0, 8'd3, 7'd10));
    pending_items.push_back(mk(MODE_TICK, 4'd4, 32'd7, 1'b1, 8'd0, 8'd3, 7'd10));
    pending_items.push_back(mk(MODE_TICK, 4'd4, 32'd8, 1'b1, 8'd0, 8'd3, 7'd10));
    pending_items.push_back(mk(MODE_TICK, 4'd4, 32'd9, 1'b1, 8'd0, 8'd3, 7'd127));
    pending_items.push_back(mk(MODE_SPARE, 4'd4, 32'd10, 1'b1, 8'd5, 8'd5, 7'd5));
    pending_items.push_back(mk(MODE_TRIGGER, 4'd9, 32'd11, 1'b1, 8'd5, 8'd5, 7'd5));
    pending_items.push_back(mk(MODE_TICK, 4'd15, 32'hFFFF_FFFF, 1'b1, 8'd255, 8'd255, 7'd127));
    pending_items.push_back(mk(MODE_TRIGGER, 4'd8, 32'hFFFF_FFFF, 1'b1, 8'd255, 8'd255, 7'd127));
    pending_items.push_back(mk(MODE_TICK, 4'd8, 32'd0, 1'b1, 8'd255, 8'd255, 7'd127));
    pending_items.push_back(mk(MODE_RELEASE, 4'd5, 32'd0, 1'b1, 8'd0, 8'd0, 7'd0));
    directed_cnt = pending_items.size();

    seq_items = 0;
    t = $urandom;
    while (seq_items < 1050) begin
      if ($urandom_range(0, 99) < 80) begin
        v = $urandom_range(0, NV - 1);
        a = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 20));
        d = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 20));
        if ($urandom_range(0, 9) == 0) begin
          a = '0;
          d = '0;
        end
        s = 7'($urandom_range(0, 127));
        pending_items.push_back(mk(MODE_TRIGGER, 4'(v), t, 1'b1, a, d, s));
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++) begin
          t = t + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 100000) :
                   $urandom_range(0, 300));
          if ($urandom_range(0, 7) == 0) s = 7'($urandom_range(0, 127));
          pending_items.push_back(mk(MODE_TICK, 4'(v), t, $urandom_range(0, 9) != 0,
                                     a, d, s));
        end
        seq_items += n + 1;
        if ($urandom_range(0, 1) == 0) begin
          pending_items.push_back(mk(MODE_RELEASE, 4'(v), t, 1'b1, a, d, s));
          seq_items++;
        end
      end else begin
        pending_items.push_back(mk(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                                   $urandom, 1'($urandom_range(0, 1)),
                                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   7'($urandom_range(0, 127))));
        seq_items++;
      end
    end
    pending_items[directed_cnt].hold = 1'b1;
    pending_items[directed_cnt + 600].hold = 1'b1;
    total_items = pending_items.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (sent_cnt != total_items || got_cnt != sent_cnt) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/ads_pkg.sv
hdl/ads_voice_store.sv
hdl/ads_sequencer.sv
hdl/ads_datapath.sv
hdl/ads_envelope_generator_core.sv
verif/ads_envelope_generator_core_tb.sv
